@@ hw/rtl/spbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package spbp_pkg;

  // Sync pair that opens every packet
  localparam logic [7:0] SyncFirst  = 8'hAA;
  localparam logic [7:0] SyncSecond = 8'h55;

  // Parse phase codes
  localparam int unsigned PhaseW = 4;
  localparam logic [PhaseW-1:0] PhHunt1   = 4'd0;
  localparam logic [PhaseW-1:0] PhHunt2   = 4'd1;
  localparam logic [PhaseW-1:0] PhKind    = 4'd2;
  localparam logic [PhaseW-1:0] PhCount   = 4'd3;
  localparam logic [PhaseW-1:0] PhStartLo = 4'd4;
  localparam logic [PhaseW-1:0] PhStartHi = 4'd5;
  localparam logic [PhaseW-1:0] PhStopLo  = 4'd6;
  localparam logic [PhaseW-1:0] PhStopHi  = 4'd7;
  localparam logic [PhaseW-1:0] PhSpareLo = 4'd8;
  localparam logic [PhaseW-1:0] PhSpareHi = 4'd9;
  localparam logic [PhaseW-1:0] PhRecords = 4'd10;

  // Byte position inside a measurement record
  localparam logic [1:0] RecQuality = 2'd0;
  localparam logic [1:0] RecDistHi  = 2'd1;
  localparam logic [1:0] RecDistLo  = 2'd2;

endpackage

`default_nettype wire

@@ hw/rtl/scan_packet_byte_parser_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// ------------------------------------------------------------------------------
// in        request    in_valid_i / in_stall_o  rx_byte_i
// out       result     out_valid_o / out_stall_i quality_o, distance_o,
//                                               record_index_o, packet_kind_o,
//                                               start_angle_o, stop_angle_o,
//                                               spare_word_o, last_record_o
//
// One byte per cycle while in_stall_o is low. Each accepted byte updates the parse
// state in the same edge; the third byte of a record loads the result register,
// so a result is visible in the cycle after its last byte is accepted.
// Reset (rst_ni low, asynchronous) returns to hunting the first sync byte and
// empties the result register.
// in_stall_o is high only while a result is held and the out side stalls; a
// result leaving in the same cycle frees the slot for the next byte.

module scan_packet_byte_parser_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       quality_o,
  output logic [15:0]      distance_o,
  output logic [7:0]       record_index_o,
  output logic [7:0]       packet_kind_o,
  output logic [15:0]      start_angle_o,
  output logic [15:0]      stop_angle_o,
  output logic [15:0]      spare_word_o,
  output logic             last_record_o
);

  // Parse state
  logic [spbp_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [1:0]  rec_pos_q, rec_pos_d;
  logic [7:0]  rec_done_q, rec_done_d;
  logic [7:0]  rec_total_q, rec_total_d;
  logic [7:0]  kind_q, kind_d;
  logic [15:0] start_q, start_d;
  logic [15:0] stop_q, stop_d;
  logic [15:0] spare_q, spare_d;
  logic [7:0]  qual_q, qual_d;
  logic [7:0]  dist_hi_q, dist_hi_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic        emit;
  logic        accept;
  logic        last_rec;
  logic [7:0]  rec_next;

  logic [7:0]  res_quality_q;
  logic [15:0] res_distance_q;
  logic [7:0]  res_index_q;
  logic [7:0]  res_kind_q;
  logic [15:0] res_start_q;
  logic [15:0] res_stop_q;
  logic [15:0] res_spare_q;
  logic        res_last_q;

  // Slot is free when empty or being drained this cycle
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign rec_next = rec_done_q + 8'd1;
  assign last_rec = (rec_next == rec_total_q);

  always_comb begin
    phase_d     = phase_q;
    rec_pos_d   = rec_pos_q;
    rec_done_d  = rec_done_q;
    rec_total_d = rec_total_q;
    kind_d      = kind_q;
    start_d     = start_q;
    stop_d      = stop_q;
    spare_d     = spare_q;
    qual_d      = qual_q;
    dist_hi_d   = dist_hi_q;
    emit        = 1'b0;

    if (accept) begin
      case (phase_q)
        spbp_pkg::PhHunt2: begin
          // a wrong second byte is not retried as a first sync byte
          phase_d = (rx_byte_i == spbp_pkg::SyncSecond) ? spbp_pkg::PhKind
                                                        : spbp_pkg::PhHunt1;
        end
        spbp_pkg::PhKind: begin
          kind_d  = rx_byte_i;
          phase_d = spbp_pkg::PhCount;
        end
        spbp_pkg::PhCount: begin
          rec_total_d = rx_byte_i;
          phase_d     = spbp_pkg::PhStartLo;
        end
        spbp_pkg::PhStartLo: begin
          start_d = {8'h00, rx_byte_i};
          phase_d = spbp_pkg::PhStartHi;
        end
        spbp_pkg::PhStartHi: begin
          start_d = {rx_byte_i, start_q[7:0]};
          phase_d = spbp_pkg::PhStopLo;
        end
        spbp_pkg::PhStopLo: begin
          stop_d  = {8'h00, rx_byte_i};
          phase_d = spbp_pkg::PhStopHi;
        end
        spbp_pkg::PhStopHi: begin
          stop_d  = {rx_byte_i, stop_q[7:0]};
          phase_d = spbp_pkg::PhSpareLo;
        end
        spbp_pkg::PhSpareLo: begin
          spare_d = {8'h00, rx_byte_i};
          phase_d = spbp_pkg::PhSpareHi;
        end
        spbp_pkg::PhSpareHi: begin
          spare_d = {rx_byte_i, spare_q[7:0]};
          // empty packet: straight back to hunting
          phase_d = (rec_total_q == 8'd0) ? spbp_pkg::PhHunt1 : spbp_pkg::PhRecords;
        end
        spbp_pkg::PhRecords: begin
          case (rec_pos_q)
            spbp_pkg::RecDistHi: begin
              dist_hi_d = rx_byte_i;
              rec_pos_d = spbp_pkg::RecDistLo;
            end
            spbp_pkg::RecDistLo: begin
              emit       = 1'b1;
              rec_pos_d  = spbp_pkg::RecQuality;
              rec_done_d = rec_next;
              if (last_rec) begin
                phase_d = spbp_pkg::PhHunt1;
              end
            end
            default: begin
              // quality byte; the unused position code behaves the same
              qual_d    = rx_byte_i;
              rec_pos_d = spbp_pkg::RecDistHi;
            end
          endcase
        end
        default: begin
          // hunting first sync byte, also any unused phase code
          if (rx_byte_i == spbp_pkg::SyncFirst) begin
            rec_pos_d  = spbp_pkg::RecQuality;
            rec_done_d = 8'd0;
            phase_d    = spbp_pkg::PhHunt2;
          end else begin
            phase_d = spbp_pkg::PhHunt1;
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= spbp_pkg::PhHunt1;
      rec_pos_q   <= spbp_pkg::RecQuality;
      rec_done_q  <= 8'd0;
      rec_total_q <= 8'd0;
      kind_q      <= 8'd0;
      start_q     <= 16'd0;
      stop_q      <= 16'd0;
      spare_q     <= 16'd0;
      qual_q      <= 8'd0;
      dist_hi_q   <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      rec_pos_q   <= rec_pos_d;
      rec_done_q  <= rec_done_d;
      rec_total_q <= rec_total_d;
      kind_q      <= kind_d;
      start_q     <= start_d;
      stop_q      <= stop_d;
      spare_q     <= spare_d;
      qual_q      <= qual_d;
      dist_hi_q   <= dist_hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded only when a record completes
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_quality_q  <= qual_q;
      res_distance_q <= {dist_hi_q, rx_byte_i};
      res_index_q    <= rec_done_q;
      res_kind_q     <= kind_q;
      res_start_q    <= start_q;
      res_stop_q     <= stop_q;
      res_spare_q    <= spare_q;
      res_last_q     <= last_rec;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign quality_o      = res_quality_q;
  assign distance_o     = res_distance_q;
  assign record_index_o = res_index_q;
  assign packet_kind_o  = res_kind_q;
  assign start_angle_o  = res_start_q;
  assign stop_angle_o   = res_stop_q;
  assign spare_word_o   = res_spare_q;
  assign last_record_o  = res_last_q;

endmodule

`default_nettype wire

@@ hw/rtl/spbp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module spbp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  quality_o,
  input wire logic [15:0] distance_o,
  input wire logic [7:0]  record_index_o
);

  // held result stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(quality_o) && $stable(distance_o)
                                   && $stable(record_index_o))
    else $error("result payload changed while stalled");

  // input is stalled only by a full, stalled result slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending result");

  // a fresh result needs a byte accepted on the edge before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o && out_stall_i)
      |-> $past(in_valid_i && !in_stall_o))
    else $error("result appeared without an accepted byte");

endmodule

bind scan_packet_byte_parser_unit spbp_checker u_spbp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .quality_o      (quality_o),
  .distance_o     (distance_o),
  .record_index_o (record_index_o)
);

`default_nettype wire
